@@ sv/dq0pt_pkg.sv @@
`default_nettype none
package dq0pt_pkg;

    // sample and angle widths follow the fixed field widths of the channels
    localparam int DATA_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int DEF_SINE_INDEX_BITS = 10;

    localparam int FRAC_BITS = DATA_BITS - 1;
    localparam int PROD_BITS = 2 * DATA_BITS;
    localparam int SUM_BITS = 2 * DATA_BITS + 2;
    localparam int VAL_BITS = DATA_BITS + 4;
    localparam int RECIP_SHIFT = VAL_BITS + 2;
    localparam int RECIP_BITS = VAL_BITS + 1;
    localparam int MUL_BITS = VAL_BITS + RECIP_BITS;
    localparam int Q_BITS = MUL_BITS - RECIP_SHIFT;

    // floor(2^RECIP_SHIFT / 3), error of the quotient estimate is at most one
    localparam logic [RECIP_BITS-1:0] RECIP_THIRD = RECIP_BITS'((64'd1 << RECIP_SHIFT) / 3);
    // makes every dividend non-negative before the divide by three
    localparam logic [VAL_BITS-1:0] DIV_OFFSET = VAL_BITS'(3) << (VAL_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] ANGLE_THIRD =
        ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);

    // odd polynomial for sin(pi/2 * t), Q30 coefficients
    localparam longint unsigned PC1 = 64'd1686629713;
    localparam longint unsigned PC3 = 64'd693598668;
    localparam longint unsigned PC5 = 64'd85569306;
    localparam longint unsigned PC7 = 64'd5026995;
    localparam longint unsigned PC9 = 64'd172272;

    typedef enum logic [1:0] {
        REQ_FWD_POS = 2'd0,
        REQ_INV_POS = 2'd1,
        REQ_FWD_NEG = 2'd2,
        REQ_INV_NEG = 2'd3
    } req_type_t;

    typedef logic signed [DATA_BITS-1:0] sample_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [ANGLE_BITS-1:0]  angle;
        sample_t                in_x;
        sample_t                in_y;
        sample_t                in_z;
    } dq0pt_in_t;

    typedef struct packed {
        sample_t out_x;
        sample_t out_y;
        sample_t out_z;
        logic    saturated;
    } dq0pt_out_t;

    // sine and cosine at the three phase angles, sine already sign-flipped
    // for the negative sequence modes
    typedef struct packed {
        req_type_t                  req_type;
        sample_t                    in_x;
        sample_t                    in_y;
        sample_t                    in_z;
        logic [2:0][DATA_BITS-1:0]  sn;
        logic [2:0][DATA_BITS-1:0]  cs;
    } dq0pt_trig_t;

    // unscaled lane sums
    typedef struct packed {
        req_type_t                 req_type;
        logic [2:0][SUM_BITS-1:0]  acc;
    } dq0pt_sum_t;

    function automatic logic is_inverse(input req_type_t r);
        return (r == REQ_INV_POS) || (r == REQ_INV_NEG);
    endfunction

    function automatic logic is_negative(input req_type_t r);
        return (r == REQ_FWD_NEG) || (r == REQ_INV_NEG);
    endfunction

    // sin(pi/2 * k / 2^(sib-2)) as an unsigned Q0.15 magnitude, k in [0, 2^(sib-2)]
    function automatic logic [FRAC_BITS-1:0] quarter_sine(input longint unsigned k,
                                                          input int sib);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned h;
        longint unsigned s;
        t = k << (30 - (sib - 2));
        t2 = (t * t) >> 30;
        h = PC9;
        h = PC7 - ((t2 * h) >> 30);
        h = PC5 - ((t2 * h) >> 30);
        h = PC3 - ((t2 * h) >> 30);
        h = PC1 - ((t2 * h) >> 30);
        s = (t * h) >> 30;
        s = (s + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (s > ((64'd1 << FRAC_BITS) - 64'd1)) begin
            s = (64'd1 << FRAC_BITS) - 64'd1;
        end
        return FRAC_BITS'(s);
    endfunction

endpackage
`default_nettype wire

@@ sv/dq0pt_angle.sv @@
`default_nettype none
module dq0pt_angle
    import dq0pt_pkg::*;
#(
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dq0pt_in_t    in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output dq0pt_trig_t       out_data
);

    localparam int QTR_ENTRIES = 1 << (SINE_INDEX_BITS - 2);
    localparam int QIDX_BITS = SINE_INDEX_BITS - 1;
    localparam int RND_SHIFT = ANGLE_BITS - SINE_INDEX_BITS;
    localparam logic [ANGLE_BITS-1:0] RND_HALF = ANGLE_BITS'(1) << (RND_SHIFT - 1);
    localparam logic [SINE_INDEX_BITS-1:0] QTR_TURN = SINE_INDEX_BITS'(QTR_ENTRIES);
    localparam logic [QIDX_BITS-1:0] QTR_POS = QIDX_BITS'(QTR_ENTRIES);

    // quarter-wave sine table, constant logic
    logic [FRAC_BITS-1:0] qtab [QTR_ENTRIES+1];

    for (genvar g = 0; g <= QTR_ENTRIES; g++) begin : g_qtab
        assign qtab[g] = quarter_sine(g, SINE_INDEX_BITS);
    end

    logic a_en;
    logic b_en;
    logic a_valid_reg;
    logic b_valid_reg;

    logic [ANGLE_BITS-1:0]              ang_ph [3];
    logic [ANGLE_BITS-1:0]              ang_rnd [3];
    logic [2:0][SINE_INDEX_BITS-1:0]    a_idx_next;
    logic [2:0][SINE_INDEX_BITS-1:0]    a_idx_reg;
    dq0pt_in_t                          a_data_reg;

    logic [SINE_INDEX_BITS-1:0] lk_idx [6];
    logic [1:0]                 lk_quad [6];
    logic [SINE_INDEX_BITS-3:0] lk_rem [6];
    logic [QIDX_BITS-1:0]       lk_pos [6];
    logic                       lk_neg [6];
    logic [DATA_BITS-1:0]       lk_val [6];
    logic                       neg_seq;
    dq0pt_trig_t                b_data_next;
    dq0pt_trig_t                b_data_reg;

    assign b_en = !b_valid_reg || out_ready;
    assign a_en = !a_valid_reg || b_en;
    assign in_ready = a_en;

    // stage a: phase angles and rounding to table index
    always_comb begin
        ang_ph[0] = in_data.angle;
        ang_ph[1] = in_data.angle - ANGLE_THIRD;
        ang_ph[2] = in_data.angle + ANGLE_THIRD;
        for (int k = 0; k < 3; k++) begin
            ang_rnd[k] = ang_ph[k] + RND_HALF;
            a_idx_next[k] = ang_rnd[k][ANGLE_BITS-1:RND_SHIFT];
        end
    end

    // stage b: quadrant fold and table read, sine then cosine
    assign neg_seq = is_negative(a_data_reg.req_type);

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            if (l < 3) begin
                lk_idx[l] = a_idx_reg[l];
            end else begin
                lk_idx[l] = a_idx_reg[l-3] + QTR_TURN;
            end
            lk_quad[l] = lk_idx[l][SINE_INDEX_BITS-1 -: 2];
            lk_rem[l] = lk_idx[l][SINE_INDEX_BITS-3:0];
            lk_pos[l] = lk_quad[l][0] ? QTR_POS - QIDX_BITS'(lk_rem[l]) : QIDX_BITS'(lk_rem[l]);
            lk_neg[l] = lk_quad[l][1] ^ ((l < 3) && neg_seq);
            lk_val[l] = lk_neg[l] ? -{1'b0, qtab[lk_pos[l]]} : {1'b0, qtab[lk_pos[l]]};
        end
        b_data_next.req_type = a_data_reg.req_type;
        b_data_next.in_x = a_data_reg.in_x;
        b_data_next.in_y = a_data_reg.in_y;
        b_data_next.in_z = a_data_reg.in_z;
        for (int k = 0; k < 3; k++) begin
            b_data_next.sn[k] = lk_val[k];
            b_data_next.cs[k] = lk_val[k+3];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_en) begin
                a_valid_reg <= in_valid;
            end
            if (b_en) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_en) begin
            a_idx_reg <= a_idx_next;
            a_data_reg <= in_data;
        end
        if (b_en) begin
            b_data_reg <= b_data_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data = b_data_reg;

endmodule
`default_nettype wire

@@ sv/dq0pt_mac.sv @@
`default_nettype none
module dq0pt_mac
    import dq0pt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dq0pt_trig_t  in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output dq0pt_sum_t        out_data
);

    logic c_en;
    logic d_en;
    logic c_valid_reg;
    logic d_valid_reg;

    sample_t                     xyz [3];
    sample_t                     op_c [3];
    sample_t                     op_s [3];
    logic signed [PROD_BITS-1:0] pc_next [3];
    logic signed [PROD_BITS-1:0] ps_next [3];
    logic signed [PROD_BITS-1:0] pc_reg [3];
    logic signed [PROD_BITS-1:0] ps_reg [3];
    req_type_t                   c_req_reg;
    sample_t                     c_x_reg;
    sample_t                     c_y_reg;
    sample_t                     c_z_reg;

    logic signed [SUM_BITS-1:0]  z_term;
    logic signed [SUM_BITS-1:0]  xyz_sum;
    dq0pt_sum_t                  d_data_next;
    dq0pt_sum_t                  d_data_reg;

    assign d_en = !d_valid_reg || out_ready;
    assign c_en = !c_valid_reg || d_en;
    assign in_ready = c_en;

    // stage c: six products, operands picked by direction
    always_comb begin
        xyz[0] = in_data.in_x;
        xyz[1] = in_data.in_y;
        xyz[2] = in_data.in_z;
        for (int k = 0; k < 3; k++) begin
            op_c[k] = is_inverse(in_data.req_type) ? in_data.in_x : xyz[k];
            op_s[k] = is_inverse(in_data.req_type) ? in_data.in_y : xyz[k];
            pc_next[k] = op_c[k] * $signed(in_data.cs[k]);
            ps_next[k] = op_s[k] * $signed(in_data.sn[k]);
        end
    end

    // stage d: lane sums
    always_comb begin
        z_term = SUM_BITS'(c_z_reg) <<< FRAC_BITS;
        xyz_sum = SUM_BITS'(c_x_reg) + SUM_BITS'(c_y_reg) + SUM_BITS'(c_z_reg)
                + SUM_BITS'(1);
        d_data_next.req_type = c_req_reg;
        if (is_inverse(c_req_reg)) begin
            for (int k = 0; k < 3; k++) begin
                d_data_next.acc[k] = SUM_BITS'(pc_reg[k]) + SUM_BITS'(ps_reg[k]) + z_term;
            end
        end else begin
            d_data_next.acc[0] = SUM_BITS'(pc_reg[0]) + SUM_BITS'(pc_reg[1])
                               + SUM_BITS'(pc_reg[2]);
            d_data_next.acc[1] = SUM_BITS'(ps_reg[0]) + SUM_BITS'(ps_reg[1])
                               + SUM_BITS'(ps_reg[2]);
            d_data_next.acc[2] = xyz_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else begin
            if (c_en) begin
                c_valid_reg <= in_valid;
            end
            if (d_en) begin
                d_valid_reg <= c_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (c_en) begin
            pc_reg <= pc_next;
            ps_reg <= ps_next;
            c_req_reg <= in_data.req_type;
            c_x_reg <= in_data.in_x;
            c_y_reg <= in_data.in_y;
            c_z_reg <= in_data.in_z;
        end
        if (d_en) begin
            d_data_reg <= d_data_next;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_data = d_data_reg;

endmodule
`default_nettype wire

@@ sv/dq0pt_scale.sv @@
`default_nettype none
module dq0pt_scale
    import dq0pt_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire dq0pt_sum_t   in_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output dq0pt_out_t        out_data
);

    localparam int WIDE_BITS = SUM_BITS + 2;
    localparam logic signed [WIDE_BITS-1:0] FWD_BIAS = WIDE_BITS'(3) <<< FRAC_BITS;
    localparam logic signed [SUM_BITS-1:0] INV_BIAS = SUM_BITS'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [VAL_BITS-1:0] Q_BIAS = VAL_BITS'(1) <<< (VAL_BITS - 2);
    localparam logic signed [VAL_BITS-1:0] SAT_HI = VAL_BITS'((1 << FRAC_BITS) - 1);
    localparam logic signed [VAL_BITS-1:0] SAT_LO = -SAT_HI - VAL_BITS'(1);

    logic e_en, f_en, g_en, h_en, o_en;
    logic e_valid_reg, f_valid_reg, g_valid_reg, h_valid_reg, o_valid_reg;
    logic e_div_reg, f_div_reg, g_div_reg, h_div_reg;

    logic signed [WIDE_BITS-1:0] wide [3];
    logic signed [SUM_BITS-1:0]  rnd [3];
    logic signed [VAL_BITS-1:0]  e_val_next [3];
    logic signed [VAL_BITS-1:0]  e_val_reg [3];
    logic signed [VAL_BITS-1:0]  f_val_reg [3];
    logic signed [VAL_BITS-1:0]  g_val_reg [3];
    logic signed [VAL_BITS-1:0]  h_val_reg [3];
    logic [VAL_BITS-1:0]         f_u_reg [3];
    logic [VAL_BITS-1:0]         g_u_reg [3];
    logic [MUL_BITS-1:0]         g_prod_reg [3];
    logic [Q_BITS-1:0]           q_est [3];
    logic [VAL_BITS-1:0]         three_q [3];
    logic [VAL_BITS-1:0]         rem [3];
    logic [Q_BITS-1:0]           h_q_next [3];
    logic [Q_BITS-1:0]           h_q_reg [3];
    logic signed [VAL_BITS-1:0]  res [3];
    logic signed [VAL_BITS-1:0]  clip [3];
    logic [2:0]                  clip_hit;
    dq0pt_out_t                  o_data_next;
    dq0pt_out_t                  o_data_reg;

    assign o_en = !o_valid_reg || out_ready;
    assign h_en = !h_valid_reg || o_en;
    assign g_en = !g_valid_reg || h_en;
    assign f_en = !f_valid_reg || g_en;
    assign e_en = !e_valid_reg || f_en;
    assign in_ready = e_en;

    // stage e: rounding shift; forward d, q and 0 keep a factor of three to divide out
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wide[k] = (WIDE_BITS'($signed(in_data.acc[k])) <<< 2) + FWD_BIAS;
            rnd[k] = $signed(in_data.acc[k]) + INV_BIAS;
            if (is_inverse(in_data.req_type)) begin
                e_val_next[k] = VAL_BITS'(rnd[k] >>> FRAC_BITS);
            end else if (k == 2) begin
                e_val_next[k] = VAL_BITS'($signed(in_data.acc[k]));
            end else begin
                e_val_next[k] = VAL_BITS'(wide[k] >>> (FRAC_BITS + 1));
            end
        end
    end

    // stage h: quotient estimate corrected by one compare
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            q_est[k] = g_prod_reg[k][MUL_BITS-1:RECIP_SHIFT];
            three_q[k] = (VAL_BITS'(q_est[k]) << 1) + VAL_BITS'(q_est[k]);
            rem[k] = g_u_reg[k] - three_q[k];
            h_q_next[k] = q_est[k] + Q_BITS'(rem[k] >= VAL_BITS'(3));
        end
    end

    // output stage: remove the offset from divided lanes and clip to the sample range
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            res[k] = h_div_reg ? $signed({1'b0, h_q_reg[k]}) - Q_BIAS : h_val_reg[k];
            clip_hit[k] = 1'b0;
            clip[k] = res[k];
            if (res[k] > SAT_HI) begin
                clip[k] = SAT_HI;
                clip_hit[k] = 1'b1;
            end else if (res[k] < SAT_LO) begin
                clip[k] = SAT_LO;
                clip_hit[k] = 1'b1;
            end
        end
        o_data_next.out_x = DATA_BITS'(clip[0]);
        o_data_next.out_y = DATA_BITS'(clip[1]);
        o_data_next.out_z = DATA_BITS'(clip[2]);
        o_data_next.saturated = |clip_hit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (e_en) begin
                e_valid_reg <= in_valid;
            end
            if (f_en) begin
                f_valid_reg <= e_valid_reg;
            end
            if (g_en) begin
                g_valid_reg <= f_valid_reg;
            end
            if (h_en) begin
                h_valid_reg <= g_valid_reg;
            end
            if (o_en) begin
                o_valid_reg <= h_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (e_en) begin
            e_val_reg <= e_val_next;
            e_div_reg <= !is_inverse(in_data.req_type);
        end
        if (f_en) begin
            for (int k = 0; k < 3; k++) begin
                f_u_reg[k] <= $unsigned(e_val_reg[k]) + DIV_OFFSET;
            end
            f_val_reg <= e_val_reg;
            f_div_reg <= e_div_reg;
        end
        if (g_en) begin
            for (int k = 0; k < 3; k++) begin
                g_prod_reg[k] <= f_u_reg[k] * RECIP_THIRD;
            end
            g_u_reg <= f_u_reg;
            g_val_reg <= f_val_reg;
            g_div_reg <= f_div_reg;
        end
        if (h_en) begin
            h_q_reg <= h_q_next;
            h_val_reg <= g_val_reg;
            h_div_reg <= g_div_reg;
        end
        if (o_en) begin
            o_data_reg <= o_data_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data = o_data_reg;

endmodule
`default_nettype wire

@@ sv/dq0_park_transform.sv @@
// throughput: one word per clock while m_ready stays high; each of the nine stages holds one word and
//   takes a new one whenever its successor moves or it is empty
// reset: synchronous, active-low aresetn clears all stage valid bits; data
//   registers are not reset. no table fill is needed, the sine table is constant
`default_nettype none
module dq0_park_transform
    import dq0pt_pkg::*;
#(
    parameter int SINE_INDEX_BITS = DEF_SINE_INDEX_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire dq0pt_in_t   s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output dq0pt_out_t       m_data
);

    // angle -> trig handoff
    logic         trig_valid;
    logic         trig_ready;
    dq0pt_trig_t  trig_word;

    // mac -> scale handoff
    logic         sum_valid;
    logic         sum_ready;
    dq0pt_sum_t   sum_word;

    // stages 1-2: phase angles at 0, -1/3 and +1/3 turn, rounded to the
    // table index, then sine and cosine from the quarter-wave table
    dq0pt_angle #(
        .SINE_INDEX_BITS (SINE_INDEX_BITS)
    ) u_angle (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (trig_valid),
        .out_ready (trig_ready),
        .out_data  (trig_word)
    );

    // stages 3-4: six 16x16 products, then three lane sums
    // forward: d and q sums plus a+b+c; inverse: one sum per phase
    dq0pt_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (trig_valid),
        .in_ready  (trig_ready),
        .in_data   (trig_word),
        .out_valid (sum_valid),
        .out_ready (sum_ready),
        .out_data  (sum_word)
    );

    // stages 5-9: rounding shift, divide by three through a reciprocal
    // multiply with one correction (forward only), saturation, output register
    dq0pt_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sum_valid),
        .in_ready  (sum_ready),
        .in_data   (sum_word),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule
`default_nettype wire
